// ===== hdl/two_queue_admission_lru_assert.svh =====
// Assertion macros shared by the two-queue admission block.
`ifndef TWO_QUEUE_ADMISSION_LRU_ASSERT_SVH
`define TWO_QUEUE_ADMISSION_LRU_ASSERT_SVH
`ifndef SYNTH
// Check that the consequent holds in the same cycle as the antecedent.
`define TQA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("two_queue_admission_lru: same-cycle check failed");
// Check that the consequent holds in the cycle after the antecedent.
`define TQA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("two_queue_admission_lru: next-cycle check failed");
`else
`define TQA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TQA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/tqa_pkg.sv =====
package tqa_pkg;

	localparam int KEY_W   = 32;
	localparam int LIMIT_W = 5;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// Register index, taken from paddr[2]
	localparam logic REG_QUEUE_LIMIT = 1'b0;

	// Per-queue update operation
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_MOVE,
		OP_REMOVE
	} tqa_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} tqa_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    capture;
		logic    update;
		tqa_op_t prob_op;
		tqa_op_t main_op;
	} tqa_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic prob_found;
		logic main_found;
	} tqa_status_t;

	// Commands to one queue of cells
	typedef struct packed {
		logic    capture;
		logic    update;
		tqa_op_t op;
	} tqa_cell_cmd_t;

endpackage

// ===== hdl/two_queue_admission_lru.sv =====
// Channel   Handshake                     Payload
// request   key_valid / key_ready         key, last_of_batch
// result    result_valid / result_ready   promoted, main_hit, main_evict_valid,
//                                         main_evict_key, probation_evict_valid,
//                                         probation_evict_key, batch_done
// config    psel / penable / pready       paddr, pwrite, pwdata, prdata
//
// Each key is accepted in the idle state, where it is compared against every cell of
// both queues; in the update state the cells shift and the result register loads.
// A new key is taken only after the previous key's update; a key is accepted even
// while the previous result waits, and its update stalls until that result goes.
// Reset clears both counts and sets queue_limit to 16; cells need no clearing.

`include "two_queue_admission_lru_assert.svh"

module two_queue_admission_lru #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               key_valid,
	output logic                               key_ready,
	input  logic signed [tqa_pkg::KEY_W-1:0]   key,
	input  logic                               last_of_batch,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic                               promoted,
	output logic                               main_hit,
	output logic                               main_evict_valid,
	output logic signed [tqa_pkg::KEY_W-1:0]   main_evict_key,
	output logic                               probation_evict_valid,
	output logic signed [tqa_pkg::KEY_W-1:0]   probation_evict_key,
	output logic                               batch_done,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tqa_pkg::APB_AW-1:0]         paddr,
	input  logic [tqa_pkg::APB_DW-1:0]         pwdata,
	output logic [tqa_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);

	logic [tqa_pkg::LIMIT_W-1:0] limit_q;
	logic                        reg_sel;
	tqa_pkg::tqa_cmd_t           ctrl_cmd;
	tqa_pkg::tqa_status_t        dp_status;

	// Configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == tqa_pkg::REG_QUEUE_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tqa_pkg::LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			limit_q <= pwdata[tqa_pkg::LIMIT_W-1:0];
		end
	end

	assign prdata = reg_sel ? tqa_pkg::APB_DW'(limit_q) : '0;

	tqa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.key_valid    (key_valid),
		.key_ready    (key_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (dp_status),
		.cmd          (ctrl_cmd)
	);

	tqa_dp #(
		.DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (ctrl_cmd),
		.status                (dp_status),
		.key                   (key),
		.last_of_batch         (last_of_batch),
		.queue_limit           (limit_q),
		.promoted              (promoted),
		.main_hit              (main_hit),
		.main_evict_valid      (main_evict_valid),
		.main_evict_key        (main_evict_key),
		.probation_evict_valid (probation_evict_valid),
		.probation_evict_key   (probation_evict_key),
		.batch_done            (batch_done)
	);

	// A request occupies the block for its update cycle
	`TQA_ASSERT_NXT(a_busy_after_accept, clk, arst_n, key_valid && key_ready, !key_ready)
	// A result only appears after an update
	`TQA_ASSERT_IMP(a_result_from_update, clk, arst_n, $rose(result_valid), $past(ctrl_cmd.update))
	// Promotion never drops a probation entry
	`TQA_ASSERT_IMP(a_promote_no_drop, clk, arst_n, result_valid && promoted, !probation_evict_valid && (probation_evict_key == '0))
	// Without promotion the main queue is untouched
	`TQA_ASSERT_IMP(a_main_needs_promote, clk, arst_n, result_valid && !promoted, !main_hit && !main_evict_valid)

endmodule

// ===== hdl/tqa_cells.sv =====
module tqa_cells #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tqa_pkg::tqa_cell_cmd_t      cmd,
	input  logic [tqa_pkg::KEY_W-1:0]   probe_key,
	input  logic [tqa_pkg::KEY_W-1:0]   push_key,
	input  logic [CW-1:0]               limit,
	output logic                        found,
	output logic                        drop_valid,
	output logic [tqa_pkg::KEY_W-1:0]   drop_key
);

	logic [tqa_pkg::KEY_W-1:0] cell_q [DEPTH];
	logic [tqa_pkg::KEY_W-1:0] cell_d [DEPTH];
	logic [CW-1:0]             count_q;
	logic [DEPTH-1:0]          match;
	logic [CW-1:0]             match_idx;
	logic [CW-1:0]             idx_s1;
	logic                      found_s1;
	logic                      full;

	// Compare the probe key against every occupied cell
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = (CW'(i) < count_q) && (cell_q[i] == probe_key);
		end
	end

	// Encode the match position; keys are unique within a queue
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				match_idx = match_idx | CW'(i);
			end
		end
	end

	// Hold the search result for the update cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_s1 <= 1'b0;
			idx_s1   <= '0;
		end else if (cmd.capture) begin
			found_s1 <= |match;
			idx_s1   <= match_idx;
		end
	end

	assign found = found_s1;

	// Queue at its limit drops the last entry on a push
	assign full       = (count_q >= limit) && (count_q != '0);
	assign drop_valid = (cmd.op == tqa_pkg::OP_PUSH) && full;

	// Pick the last occupied cell
	always_comb begin
		drop_key = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (CW'(i + 1) == count_q) begin
				drop_key = drop_key | cell_q[i];
			end
		end
	end

	// Next value of each cell: shift toward the back or close a gap
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		localparam logic [CW-1:0] JC = CW'(j);
		localparam logic [CW-1:0] JN = CW'(j + 1);
		logic [tqa_pkg::KEY_W-1:0] prev_key;
		logic [tqa_pkg::KEY_W-1:0] next_key;

		if (j == 0) begin : g_head
			assign prev_key = push_key;
		end else begin : g_body
			assign prev_key = cell_q[j-1];
		end

		if (j == DEPTH - 1) begin : g_tail
			assign next_key = cell_q[j];
		end else begin : g_mid
			assign next_key = cell_q[j+1];
		end

		always_comb begin
			cell_d[j] = cell_q[j];
			case (cmd.op)
				tqa_pkg::OP_PUSH: begin
					if ((j == 0) || (JC < count_q) || ((JC == count_q) && !full)) begin
						cell_d[j] = prev_key;
					end
				end
				tqa_pkg::OP_MOVE: begin
					if (JC <= idx_s1) begin
						cell_d[j] = prev_key;
					end
				end
				tqa_pkg::OP_REMOVE: begin
					if ((JC >= idx_s1) && (JN < count_q)) begin
						cell_d[j] = next_key;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Cell storage
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			cell_q <= cell_d;
		end
	end

	// Occupancy count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.update) begin
			case (cmd.op)
				tqa_pkg::OP_PUSH: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end
				tqa_pkg::OP_REMOVE: begin
					count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/tqa_dp.sv =====
module tqa_dp #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tqa_pkg::tqa_cmd_t                 cmd,
	output tqa_pkg::tqa_status_t              status,
	input  logic signed [tqa_pkg::KEY_W-1:0]  key,
	input  logic                              last_of_batch,
	input  logic [tqa_pkg::LIMIT_W-1:0]       queue_limit,
	output logic                              promoted,
	output logic                              main_hit,
	output logic                              main_evict_valid,
	output logic signed [tqa_pkg::KEY_W-1:0]  main_evict_key,
	output logic                              probation_evict_valid,
	output logic signed [tqa_pkg::KEY_W-1:0]  probation_evict_key,
	output logic                              batch_done
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > tqa_pkg::LIMIT_W) ? CW : tqa_pkg::LIMIT_W;

	logic [tqa_pkg::KEY_W-1:0] key_q;
	logic                      batch_q;
	logic [LW-1:0]             lim_ext;
	logic [LW-1:0]             lim_eff;
	logic [CW-1:0]             lim_c;
	tqa_pkg::tqa_cell_cmd_t    prob_cmd;
	tqa_pkg::tqa_cell_cmd_t    main_cmd;
	logic                      prob_found;
	logic                      main_found;
	logic                      prob_drop;
	logic                      main_drop;
	logic [tqa_pkg::KEY_W-1:0] prob_drop_key;
	logic [tqa_pkg::KEY_W-1:0] main_drop_key;

	// Clamp the limit to one through the queue depth
	assign lim_ext = LW'(queue_limit);
	always_comb begin
		if (lim_ext == '0) begin
			lim_eff = LW'(1);
		end else if (lim_ext > LW'(DEPTH)) begin
			lim_eff = LW'(DEPTH);
		end else begin
			lim_eff = lim_ext;
		end
	end
	assign lim_c = lim_eff[CW-1:0];

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q   <= key;
			batch_q <= last_of_batch;
		end
	end

	assign prob_cmd = '{capture: cmd.capture, update: cmd.update, op: cmd.prob_op};
	assign main_cmd = '{capture: cmd.capture, update: cmd.update, op: cmd.main_op};

	tqa_cells #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_prob (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (prob_cmd),
		.probe_key  (key),
		.push_key   (key_q),
		.limit      (lim_c),
		.found      (prob_found),
		.drop_valid (prob_drop),
		.drop_key   (prob_drop_key)
	);

	tqa_cells #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_main (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (main_cmd),
		.probe_key  (key),
		.push_key   (key_q),
		.limit      (lim_c),
		.found      (main_found),
		.drop_valid (main_drop),
		.drop_key   (main_drop_key)
	);

	assign status = '{prob_found: prob_found, main_found: main_found};

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			promoted              <= prob_found;
			main_hit              <= prob_found && main_found;
			main_evict_valid      <= main_drop;
			main_evict_key        <= main_drop ? main_drop_key : '0;
			probation_evict_valid <= prob_drop;
			probation_evict_key   <= prob_drop ? prob_drop_key : '0;
			batch_done            <= batch_q;
		end
	end

endmodule

// ===== hdl/tqa_ctrl.sv =====
module tqa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 key_valid,
	output logic                 key_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  tqa_pkg::tqa_status_t status,
	output tqa_pkg::tqa_cmd_t    cmd
);

	tqa_pkg::tqa_state_t state_q;
	tqa_pkg::tqa_state_t state_d;
	logic                result_valid_q;
	logic                slot_free;

	// Result register can take a new result this cycle
	assign slot_free = !result_valid_q || result_ready;

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		key_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.update  = 1'b0;
		cmd.prob_op = tqa_pkg::OP_HOLD;
		cmd.main_op = tqa_pkg::OP_HOLD;
		case (state_q)
			tqa_pkg::ST_IDLE: begin
				key_ready = 1'b1;
				if (key_valid) begin
					cmd.capture = 1'b1;
					state_d     = tqa_pkg::ST_UPDATE;
				end
			end
			tqa_pkg::ST_UPDATE: begin
				if (slot_free) begin
					cmd.update = 1'b1;
					state_d    = tqa_pkg::ST_IDLE;
					if (status.prob_found) begin
						cmd.prob_op = tqa_pkg::OP_REMOVE;
						cmd.main_op = status.main_found ? tqa_pkg::OP_MOVE : tqa_pkg::OP_PUSH;
					end else begin
						cmd.prob_op = tqa_pkg::OP_PUSH;
					end
				end
			end
			default: begin
				state_d = tqa_pkg::ST_IDLE;
			end
		endcase
	end

	// State and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= tqa_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule
